FILE: sv/prrs_pkg.sv
// Shared types and constants for the priority round-robin scheduler.
package prrs_pkg;

  localparam int THREAD_SLOTS_DEF   = 8;
  localparam int PRIORITY_LIMIT_DEF = 16;

  localparam int PRIO_W       = 5;
  localparam int STATUS_W     = 3;
  localparam int SLOT_OUT_W   = 3;
  localparam int SLOT_STATE_W = 2;
  localparam int IN_DATA_W    = 8;
  localparam int OUT_DATA_W   = 8;

  typedef enum logic [SLOT_STATE_W-1:0] {
    SLOT_FREE     = 2'd0,
    SLOT_RUNNABLE = 2'd1,
    SLOT_RUNNING  = 2'd2
  } slot_state_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_CREATED   = 3'd0,
    ST_FULL      = 3'd1,
    ST_SWITCHED  = 3'd2,
    ST_CONTINUES = 3'd3,
    ST_DEADLOCK  = 3'd4
  } status_e;

  typedef enum logic {
    OP_CREATE   = 1'b0,
    OP_SCHEDULE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MARK,
    SEQ_SCAN,
    SEQ_DRAIN,
    SEQ_COMMIT
  } seq_state_e;

  // Control from the sequencer to the shared compare unit.
  typedef struct packed {
    logic clear;        // restart the search
    logic step;         // one slot entry is present on the read data
    logic create_mode;  // first free slot instead of best runnable slot
  } scan_ctl_t;

endpackage

FILE: sv/prrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module prrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/prrs_scan.sv
// Shared compare unit: keeps the best slot seen so far over a slot scan.
module prrs_scan #(
  parameter int ThreadSlots   = prrs_pkg::THREAD_SLOTS_DEF,
  parameter int PriorityLimit = prrs_pkg::PRIORITY_LIMIT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  prrs_pkg::scan_ctl_t            ctl_i,
  input  prrs_pkg::slot_state_e          rd_state_i,
  input  logic [prrs_pkg::PRIO_W-1:0]    rd_prio_i,
  input  logic [$clog2(ThreadSlots)-1:0] rd_idx_i,
  output logic                           found_o,
  output logic [$clog2(ThreadSlots)-1:0] best_idx_o
);
  import prrs_pkg::*;

  localparam int SlotW = $clog2(ThreadSlots);
  localparam int BestW = $clog2(PriorityLimit + 1);
  localparam int CmpW  = (BestW > PRIO_W) ? BestW : PRIO_W;

  logic             found_q, found_d;
  logic [BestW-1:0] best_prio_q, best_prio_d;
  logic [SlotW-1:0] best_idx_q, best_idx_d;
  logic             take;

  // Create wants the first free slot; schedule wants a strictly better runnable one.
  always_comb begin
    if (ctl_i.create_mode) begin
      take = (rd_state_i == SLOT_FREE) && !found_q;
    end else begin
      take = (rd_state_i == SLOT_RUNNABLE) &&
             (CmpW'(rd_prio_i) < CmpW'(best_prio_q));
    end
  end

  always_comb begin
    found_d     = found_q;
    best_prio_d = best_prio_q;
    best_idx_d  = best_idx_q;
    if (ctl_i.clear) begin
      found_d     = 1'b0;
      best_prio_d = BestW'(PriorityLimit);
    end else if (ctl_i.step && take) begin
      found_d     = 1'b1;
      best_prio_d = BestW'(rd_prio_i);
      best_idx_d  = rd_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_prio_q <= best_prio_d;
    best_idx_q  <= best_idx_d;
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;

endmodule

FILE: sv/priority_round_robin_scheduler_core.sv
// Top level of the priority round-robin thread-slot scheduler.
//
//   channel  dir  tdata (low bit up)                       tuser
//   s_axis   in   priority_req[4:0], current_stays[5]      operation[0]
//   m_axis   out  slot[2:0]                                status[2:0]
//
// Sequence: a create runs scan, drain and commit; a schedule first marks the
//   current slot; an item that arrives once deadlocked goes straight to
//   commit. s_axis is ready only while idle, so a new word is not taken
//   until the last one is committed. The scan reads one slot per cycle
//   through the read port of the state and priority RAMs.
// Reset: per-slot valid bits make every slot read as free at once; no
//   clearing pass is run.
// Stalls: the result register holds a word while m_axis stalls and a new
//   word may be accepted meanwhile; the commit step waits for that register.
module priority_round_robin_scheduler_core #(
  parameter int ThreadSlots   = prrs_pkg::THREAD_SLOTS_DEF,
  parameter int PriorityLimit = prrs_pkg::PRIORITY_LIMIT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // priority_req[4:0], current_stays[5], zero fill [7:6]
  input  logic [prrs_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // operation[0]
  input  logic                               s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // slot[2:0], zero fill [7:3]
  output logic [prrs_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // status[2:0]
  output logic [prrs_pkg::STATUS_W-1:0]      m_axis_tuser_o
);
  import prrs_pkg::*;

  localparam int SlotW = $clog2(ThreadSlots);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(ThreadSlots - 1);

  // Sequencer state and captured input word.
  seq_state_e              seq_q, seq_d;
  op_e                     op_q, op_d;
  logic [PRIO_W-1:0]       prio_q, prio_d;
  logic                    stays_q, stays_d;

  // Architectural state outside the RAMs.
  logic [SlotW-1:0]        cur_q, cur_d;
  logic                    halted_q, halted_d;
  logic [ThreadSlots-1:0]  state_vld_q;

  // Scan bookkeeping: read address, reads issued, read in flight.
  logic [SlotW-1:0]        idx_q, idx_d;
  logic [SlotW-1:0]        cnt_q, cnt_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [SlotW-1:0]        rd_idx_q;
  logic                    vld_rd_q;

  // Result register.
  logic                    out_vld_q, out_vld_d;
  status_e                 out_status_q, out_status_d;
  logic [SLOT_OUT_W-1:0]   out_slot_q, out_slot_d;

  // RAM ports.
  logic                    state_we, prio_we;
  logic [SlotW-1:0]        waddr;
  slot_state_e             state_wdata;
  logic [SLOT_STATE_W-1:0] state_rdata;
  logic [PRIO_W-1:0]       prio_rdata;

  // Compare unit.
  scan_ctl_t               scan_ctl;
  slot_state_e             rd_state;
  logic                    found;
  logic [SlotW-1:0]        best_idx;

  logic                    in_fire;
  logic                    out_free;

  assign in_fire  = s_axis_tvalid_i && (seq_q == SEQ_IDLE);
  assign out_free = !out_vld_q || m_axis_tready_i;

  // Slots never written read as free.
  assign rd_state = vld_rd_q ? slot_state_e'(state_rdata) : SLOT_FREE;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    return (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  prrs_ram #(
    .Width(SLOT_STATE_W),
    .Depth(ThreadSlots)
  ) u_state_ram (
    .clk_i  (clk_i),
    .we_i   (state_we),
    .waddr_i(waddr),
    .wdata_i(state_wdata),
    .raddr_i(idx_q),
    .rdata_o(state_rdata)
  );

  prrs_ram #(
    .Width(PRIO_W),
    .Depth(ThreadSlots)
  ) u_prio_ram (
    .clk_i  (clk_i),
    .we_i   (prio_we),
    .waddr_i(waddr),
    .wdata_i(prio_q),
    .raddr_i(idx_q),
    .rdata_o(prio_rdata)
  );

  prrs_scan #(
    .ThreadSlots  (ThreadSlots),
    .PriorityLimit(PriorityLimit)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .rd_state_i(rd_state),
    .rd_prio_i (prio_rdata),
    .rd_idx_i  (rd_idx_q),
    .found_o   (found),
    .best_idx_o(best_idx)
  );

  always_comb begin
    seq_d        = seq_q;
    op_d         = op_q;
    prio_d       = prio_q;
    stays_d      = stays_q;
    cur_d        = cur_q;
    halted_d     = halted_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    rd_vld_d     = 1'b0;
    out_vld_d    = out_vld_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    state_we     = 1'b0;
    prio_we      = 1'b0;
    waddr        = best_idx;
    state_wdata  = SLOT_RUNNING;
    scan_ctl     = '{clear: 1'b0, step: rd_vld_q, create_mode: (op_q == OP_CREATE)};

    unique case (seq_q)
      SEQ_IDLE: begin
        if (in_fire) begin
          op_d     = op_e'(s_axis_tuser_i);
          prio_d   = s_axis_tdata_i[PRIO_W-1:0];
          stays_d  = s_axis_tdata_i[PRIO_W];
          idx_d    = '0;
          cnt_d    = '0;
          scan_ctl.clear = 1'b1;
          if (halted_q) begin
            seq_d = SEQ_COMMIT;
          end else if (op_e'(s_axis_tuser_i) == OP_SCHEDULE) begin
            seq_d = SEQ_MARK;
          end else begin
            seq_d = SEQ_SCAN;
          end
        end
      end
      SEQ_MARK: begin
        // Release the current slot, then scan from the slot after it.
        state_we    = 1'b1;
        waddr       = cur_q;
        state_wdata = stays_q ? SLOT_RUNNABLE : SLOT_FREE;
        idx_d       = next_slot(cur_q);
        seq_d       = SEQ_SCAN;
      end
      SEQ_SCAN: begin
        rd_vld_d = 1'b1;
        idx_d    = next_slot(idx_q);
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == LastSlot) begin
          seq_d = SEQ_DRAIN;
        end
      end
      SEQ_DRAIN: begin
        // Last entry is applied to the compare unit in this cycle.
        seq_d = SEQ_COMMIT;
      end
      SEQ_COMMIT: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_slot_d = '0;
          seq_d      = SEQ_IDLE;
          if (halted_q) begin
            out_status_d = ST_DEADLOCK;
          end else if (op_q == OP_CREATE) begin
            if (found) begin
              state_we     = 1'b1;
              prio_we      = 1'b1;
              state_wdata  = SLOT_RUNNABLE;
              out_status_d = ST_CREATED;
              out_slot_d   = SLOT_OUT_W'(best_idx);
            end else begin
              out_status_d = ST_FULL;
            end
          end else begin
            if (found) begin
              state_we     = 1'b1;
              state_wdata  = SLOT_RUNNING;
              out_slot_d   = SLOT_OUT_W'(best_idx);
              out_status_d = (best_idx == cur_q) ? ST_CONTINUES : ST_SWITCHED;
              cur_d        = best_idx;
            end else begin
              halted_d     = 1'b1;
              out_status_d = ST_DEADLOCK;
            end
          end
        end
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q       <= SEQ_IDLE;
      cur_q       <= '0;
      halted_q    <= 1'b0;
      state_vld_q <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      seq_q    <= seq_d;
      cur_q    <= cur_d;
      halted_q <= halted_d;
      idx_q    <= idx_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      out_vld_q <= out_vld_d;
      if (state_we) begin
        state_vld_q[waddr] <= 1'b1;
      end
    end
  end

  // Payload: captured fields, read tags and result word.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    prio_q       <= prio_d;
    stays_q      <= stays_d;
    rd_idx_q     <= idx_q;
    vld_rd_q     <= state_vld_q[idx_q];
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
  end

  assign s_axis_tready_o = (seq_q == SEQ_IDLE);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_DATA_W'(out_slot_q);
  assign m_axis_tuser_o  = out_status_q;

`ifndef ASSERT_OFF
  // Once halted, only a reset brings the block back.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halted flag dropped without reset");

  // While halted, any result word shown is a deadlock report.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && halted_q) |-> (out_status_q == ST_DEADLOCK))
    else $error("non-deadlock result while halted");

  // The scan pipeline is empty when the result is committed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SEQ_COMMIT) |-> !rd_vld_q)
    else $error("slot read still in flight at commit");

  // A switch moves the current slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((seq_q == SEQ_COMMIT) && out_free && !halted_q && (op_q == OP_SCHEDULE) &&
     found && (best_idx != cur_q)) |=> (cur_q != $past(cur_q)))
    else $error("switch did not update the current slot");
`endif

endmodule

FILE: dv/priority_round_robin_scheduler_core_tb.sv
// Self-checking testbench for the priority round-robin thread-slot scheduler core.
`timescale 1ns / 1ps

module priority_round_robin_scheduler_core_tb;
  import prrs_pkg::*;

  localparam int SLOTS            = THREAD_SLOTS_DEF;
  localparam int PRIO_LIMIT       = PRIORITY_LIMIT_DEF;
  localparam int CLK_HALF_NS      = 4;
  localparam int RESET_CYCLES     = 10;
  localparam int SINK_HOLD_CYCLES = 200;  // long output stall, well past the buffering
  localparam int WATCHDOG_LIMIT   = 2000; // cycles with no word moving on either side
  localparam int SETTLE_CYCLES    = 20;   // longer than a schedule takes to complete

  // One expected result word: status on tuser, slot on tdata.
  typedef struct packed {
    status_e    status;
    logic [2:0] slot;
  } sched_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  // priority_req[4:0], current_stays[5], zero fill [7:6]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i = '0;
  // operation[0]
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  // slot[2:0], zero fill [7:3]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  // status[2:0]
  logic [STATUS_W-1:0]   m_axis_tuser_o;

  // Shadow copy of the slot table, updated as each word is accepted.
  slot_state_e   slot_st[SLOTS];
  logic [4:0]    slot_prio[SLOTS];
  bit            prio_known[SLOTS];   // priority written at least once
  logic [2:0]    cur_slot;
  bit            sched_halted;

  sched_result_t pending_results[$];
  int            fail_count;
  int            stall_cycles;
  bit            idle_en;
  bit            sink_hold_req;

  priority_round_robin_scheduler_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #CLK_HALF_NS clk_i = ~clk_i;
  end

  // Search for the next thread as a schedule with the given stays flag would,
  // without touching the shadow table. The current slot is taken as already
  // marked runnable or free. Ties keep the first slot met after the current one.
  function automatic bit pick_slot(input logic stays, output logic [2:0] best);
    int          best_prio;
    int          idx;
    bit          found;
    slot_state_e st;
    best_prio = PRIO_LIMIT;
    found     = 1'b0;
    best      = '0;
    for (int i = 0; i < SLOTS; i++) begin
      idx = (int'(cur_slot) + 1 + i) % SLOTS;
      if (idx == int'(cur_slot)) begin
        st = stays ? SLOT_RUNNABLE : SLOT_FREE;
      end else begin
        st = slot_st[idx];
      end
      if (st == SLOT_RUNNABLE && int'(slot_prio[idx]) < best_prio) begin
        best_prio = slot_prio[idx];
        best      = idx[2:0];
        found     = 1'b1;
      end
    end
    return found;
  endfunction

  // Advance the shadow table by one accepted word and return its result.
  function automatic sched_result_t predict_word(op_e op, logic [4:0] prio, logic stays);
    sched_result_t res;
    logic [2:0]    best;
    bit            found;
    res.status = ST_DEADLOCK;
    res.slot   = '0;
    if (sched_halted) return res;
    if (op == OP_CREATE) begin
      res.status = ST_FULL;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_st[s] == SLOT_FREE) begin
          slot_st[s]    = SLOT_RUNNABLE;
          slot_prio[s]  = prio;
          prio_known[s] = 1'b1;
          res.status    = ST_CREATED;
          res.slot      = s[2:0];
          break;
        end
      end
      return res;
    end
    found = pick_slot(stays, best);
    slot_st[cur_slot] = stays ? SLOT_RUNNABLE : SLOT_FREE;
    if (!found) begin
      // Current slot keeps the value it was just given; block stops for good.
      sched_halted = 1'b1;
      return res;
    end
    slot_st[best] = SLOT_RUNNING;
    res.status    = (best == cur_slot) ? ST_CONTINUES : ST_SWITCHED;
    res.slot      = best;
    cur_slot      = best;
    return res;
  endfunction

  // Offer one word, hold it until accepted, then record its expected result.
  // Valid stays high into the next word unless an idle burst follows.
  task automatic send_word(op_e op, logic [4:0] prio, logic stays);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, stays, prio};
    s_axis_tuser_i  <= op;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_results.push_back(predict_word(op, prio, stays));
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every expected result has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Random well-formed traffic: the op mix keeps the table cycling between
  // nearly empty and full, and priorities cluster low so ties are common.
  // A schedule that would stop the block is steered away from deadlock,
  // which is saved for the very end since only reset clears it.
  task automatic run_random_words(int count);
    op_e        op;
    logic [4:0] prio;
    logic       stays;
    logic [2:0] best;
    int         over_limit;
    repeat (count) begin
      op = ($urandom_range(0, 9) < 5) ? OP_SCHEDULE : OP_CREATE;
      if ($urandom_range(0, 3) == 0) begin
        prio = 5'($urandom_range(0, PRIO_LIMIT - 1));
      end else begin
        prio = 5'($urandom_range(0, 3));
      end
      // Over-limit slots never leave the table; keep only a few around.
      over_limit = 0;
      for (int s = 0; s < SLOTS; s++) begin
        if (slot_st[s] != SLOT_FREE && slot_prio[s] >= PRIO_LIMIT) over_limit++;
      end
      if (over_limit < 3 && $urandom_range(0, 15) == 0) prio = 5'(PRIO_LIMIT);
      stays = 1'($urandom_range(0, 1));
      // Never make a slot runnable whose priority was never written.
      if (!prio_known[cur_slot]) stays = 1'b0;
      if (op == OP_SCHEDULE && !pick_slot(stays, best)) begin
        if (prio_known[cur_slot] && pick_slot(1'b1, best)) begin
          stays = 1'b1;
        end else begin
          op   = OP_CREATE;
          prio = 5'($urandom_range(0, PRIO_LIMIT - 1));
        end
      end
      send_word(op, prio, stays);
    end
  endtask

  // Fill all slots with extreme and tied priorities, then overflow once.
  task automatic test_create_and_full();
    logic [4:0] fill_prio[SLOTS];
    fill_prio = '{5'd16, 5'd0, 5'd5, 5'd5, 5'd15, 5'd1, 5'd16, 5'd5};
    foreach (fill_prio[i]) send_word(OP_CREATE, fill_prio[i], 1'(i % 2));
    send_word(OP_CREATE, 5'd2, 1'b1);
  endtask

  // Walk the scheduler: switch, continue, free-and-switch, ties rotating.
  task automatic test_round_robin();
    send_word(OP_SCHEDULE, 5'd16, 1'b1);
    send_word(OP_SCHEDULE, 5'd9,  1'b1);
    send_word(OP_SCHEDULE, 5'd0,  1'b0);
    send_word(OP_SCHEDULE, 5'd31 & 5'd16, 1'b0);
    send_word(OP_SCHEDULE, 5'd7,  1'b1);
    send_word(OP_SCHEDULE, 5'd3,  1'b1);
    send_word(OP_SCHEDULE, 5'd12, 1'b1);
    send_word(OP_CREATE,   5'd3,  1'b0);
    send_word(OP_SCHEDULE, 5'd0,  1'b1);
  endtask

  // Stall the output long enough that the core backs up into its input.
  task automatic test_output_stall();
    sink_hold_req = 1'b1;
    run_random_words(40);
    while (sink_hold_req) @(posedge clk_i);
  endtask

  // Let the pipeline empty completely, then pick up again.
  task automatic test_sender_pause();
    drain_results();
    run_random_words(60);
  endtask

  task automatic test_random_mix();
    run_random_words(1350);
    // Finish without idling on either side.
    idle_en = 1'b0;
    run_random_words(300);
  endtask

  // Free the running thread until nothing is left to run, then confirm that
  // the halted block answers deadlock to everything.
  task automatic test_deadlock_halt();
    while (!sched_halted) send_word(OP_SCHEDULE, 5'($urandom_range(0, 16)), 1'b0);
    send_word(OP_CREATE,   5'd0,  1'b1);
    send_word(OP_SCHEDULE, 5'd16, 1'b1);
    send_word(OP_SCHEDULE, 5'd4,  1'b0);
    send_word(OP_CREATE,   5'd16, 1'b0);
  endtask

  // Receiver: random ready bursts, plus one long hold on request.
  initial begin : sink_ready
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (sink_hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
        sink_hold_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        m_axis_tready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    sched_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: status %0d slot %0d",
               m_axis_tuser_o, m_axis_tdata_o[2:0]);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          fail_count++;
        end
        if (m_axis_tdata_o[2:0] !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, m_axis_tdata_o[2:0]);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    fail_count    = 0;
    stall_cycles  = 0;
    idle_en       = 1'b1;
    sink_hold_req = 1'b0;
    sched_halted  = 1'b0;
    cur_slot      = '0;
    foreach (slot_st[i]) begin
      slot_st[i]    = SLOT_FREE;
      slot_prio[i]  = '0;
      prio_known[i] = 1'b0;
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_create_and_full();
    test_round_robin();
    test_output_stall();
    test_sender_pause();
    test_random_mix();
    test_deadlock_halt();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: priority_round_robin_scheduler_core.f
sv/prrs_pkg.sv
sv/prrs_ram.sv
sv/prrs_scan.sv
sv/priority_round_robin_scheduler_core.sv
dv/priority_round_robin_scheduler_core_tb.sv
